[src/vlt3_pkg.sv]
// ----------------------------------------------------------------------------
// vlt3_pkg
// Shared types and constants for the 3D voxel line walker.
// ----------------------------------------------------------------------------
package vlt3_pkg;

    localparam int CoordW      = 10;
    localparam int SizeW       = 11;
    localparam int ReachW      = 10;
    localparam int StepW       = CoordW;
    localparam int OddW        = StepW + 1;
    localparam int ProdW       = OddW + CoordW;
    localparam int NumAxes     = 3;
    localparam int GridSizeDef = 1024;

    typedef logic [CoordW-1:0] t_coord;
    typedef logic [SizeW-1:0]  t_size;
    typedef logic [ReachW-1:0] t_reach;

    localparam t_size  SizeReset  = t_size'(1024);
    localparam t_reach ReachReset = t_reach'(5);

    typedef enum logic [1:0] {
        CFG_GRID_X = 2'd0,
        CFG_GRID_Y = 2'd1,
        CFG_GRID_Z = 2'd2,
        CFG_REACH  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        BOX_NONE = 2'd0,
        BOX_CUBE = 2'd1,
        BOX_SLAB = 2'd2
    } t_box_mode;

    // description of the cell just reached, handed from walker to box logic
    typedef struct packed {
        t_coord [NumAxes-1:0] pos;
        logic   [NumAxes-1:0] dir;
        t_box_mode            mode;
        logic   [1:0]         axis;
        logic                 last;
    } t_box_req;

    typedef struct packed {
        t_coord [NumAxes-1:0] lo;
        t_coord [NumAxes-1:0] hi;
        logic                 valid;
    } t_box;

endpackage

[src/vlt3_walk.sv]
// ----------------------------------------------------------------------------
// vlt3_walk
// Segment state and one traversal step: picks the axes with the earliest
// boundary crossing by exact cross-multiplied compares.
// ----------------------------------------------------------------------------
module vlt3_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_kind,
    input  vlt3_pkg::t_coord [2:0]        i_start,
    input  vlt3_pkg::t_coord [2:0]        i_end,
    output vlt3_pkg::t_box_req            o_req
);
    import vlt3_pkg::*;

    t_coord [NumAxes-1:0] r_cur, n_cur;
    t_coord [NumAxes-1:0] r_tgt, n_tgt;
    logic   [NumAxes-1:0] r_dir, n_dir;
    t_coord [NumAxes-1:0] r_dist, n_dist;
    t_coord [NumAxes-1:0] r_steps, n_steps;
    logic                 r_active, n_active;

    logic [ProdW-1:0]     prod [NumAxes][NumAxes];
    logic [NumAxes-1:0]   earlier [NumAxes];
    logic [NumAxes-1:0]   pick;
    logic                 single;
    logic [1:0]           only;

    // (2n_a + 1) * |d_b| for every ordered pair of distinct axes
    always_comb begin
        for (int a = 0; a < NumAxes; a++) begin
            for (int b = 0; b < NumAxes; b++) begin
                if (a != b) begin
                    prod[a][b] = ProdW'({r_steps[a], 1'b1}) * ProdW'(r_dist[b]);
                end else begin
                    prod[a][b] = '0;
                end
            end
        end
        for (int a = 0; a < NumAxes; a++) begin
            for (int b = 0; b < NumAxes; b++) begin
                earlier[a][b] = (a != b) && (prod[a][b] < prod[b][a]);
            end
        end
        for (int a = 0; a < NumAxes; a++) begin
            pick[a] = 1'b1;
            for (int b = 0; b < NumAxes; b++) begin
                if (earlier[b][a]) begin
                    pick[a] = 1'b0;
                end
            end
        end
    end

    assign single = ($countones(pick) == 1);

    always_comb begin
        unique case (pick)
            3'b010:  only = 2'd1;
            3'b100:  only = 2'd2;
            default: only = 2'd0;
        endcase
    end

    always_comb begin
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_dir    = r_dir;
        n_dist   = r_dist;
        n_steps  = r_steps;
        n_active = r_active;
        o_req.mode = BOX_NONE;
        if (i_kind == KIND_LOAD) begin
            for (int a = 0; a < NumAxes; a++) begin
                n_cur[a]   = i_start[a];
                n_tgt[a]   = i_end[a];
                n_dir[a]   = (i_end[a] < i_start[a]);
                n_dist[a]  = (i_end[a] < i_start[a]) ? i_start[a] - i_end[a]
                                                     : i_end[a] - i_start[a];
                n_steps[a] = '0;
            end
            n_active   = (i_start != i_end);
            o_req.mode = BOX_CUBE;
        end else if (r_active) begin
            for (int a = 0; a < NumAxes; a++) begin
                if (pick[a]) begin
                    n_cur[a]   = r_dir[a] ? r_cur[a] - 1'b1 : r_cur[a] + 1'b1;
                    n_steps[a] = r_steps[a] + 1'b1;
                end
            end
            n_active   = (n_cur != r_tgt);
            o_req.mode = single ? BOX_SLAB : BOX_CUBE;
        end
        o_req.pos  = n_cur;
        o_req.dir  = n_dir;
        o_req.axis = only;
        o_req.last = !n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_tgt    <= '0;
            r_dir    <= '0;
            r_dist   <= '0;
            r_steps  <= '0;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_cur    <= n_cur;
            r_tgt    <= n_tgt;
            r_dir    <= n_dir;
            r_dist   <= n_dist;
            r_steps  <= n_steps;
            r_active <= n_active;
        end
    end

endmodule

[src/vlt3_box.sv]
// ----------------------------------------------------------------------------
// vlt3_box
// Protection box around the reached cell: full clipped cube, or the leading
// slab after a single-axis step.
// ----------------------------------------------------------------------------
module vlt3_box #(
    parameter int GRID_SIZE = vlt3_pkg::GridSizeDef
) (
    input  vlt3_pkg::t_box_req      i_req,
    input  vlt3_pkg::t_size [2:0]   i_size,
    input  vlt3_pkg::t_reach        i_reach,
    output vlt3_pkg::t_box          o_box
);
    import vlt3_pkg::*;

    t_size [NumAxes-1:0] lim;
    t_size [NumAxes-1:0] lo_c, hi_c;
    t_size [NumAxes-1:0] lo_s;
    t_size [NumAxes-1:0] sum;
    t_size [NumAxes-1:0] lo_w, hi_w;
    logic  [NumAxes-1:0] ok_c, ok_s, ok;
    logic                use_slab;

    always_comb begin
        for (int a = 0; a < NumAxes; a++) begin
            // a size register above the grid parameter clamps to it
            if (32'(i_size[a]) > GRID_SIZE) begin
                lim[a] = SizeW'(GRID_SIZE);
            end else begin
                lim[a] = i_size[a];
            end
            sum[a]  = SizeW'(i_req.pos[a]) + SizeW'(i_reach);
            lo_c[a] = (SizeW'(i_req.pos[a]) > SizeW'(i_reach)) ?
                      SizeW'(i_req.pos[a]) - SizeW'(i_reach) : '0;
            hi_c[a] = (sum[a] > lim[a] - 1'b1) ? lim[a] - 1'b1 : sum[a];
            ok_c[a] = (lim[a] != '0) && (lo_c[a] <= hi_c[a]);
            // leading slab, one reach ahead in the step direction
            if (!i_req.dir[a]) begin
                lo_s[a] = sum[a];
                ok_s[a] = (sum[a] < lim[a]);
            end else begin
                lo_s[a] = SizeW'(i_req.pos[a]) - SizeW'(i_reach);
                ok_s[a] = (SizeW'(i_req.pos[a]) >= SizeW'(i_reach));
            end
        end
    end

    always_comb begin
        use_slab = 1'b0;
        ok       = '0;
        unique case (i_req.mode)
            BOX_CUBE: begin
                ok = ok_c;
            end
            BOX_SLAB: begin
                use_slab = 1'b1;
                ok       = ok_c;
                ok[i_req.axis] = ok_s[i_req.axis];
            end
            default: begin
                ok = '0;
            end
        endcase
        for (int a = 0; a < NumAxes; a++) begin
            if (use_slab && (i_req.axis == 2'(a))) begin
                lo_w[a] = lo_s[a];
                hi_w[a] = lo_s[a];
            end else begin
                lo_w[a] = lo_c[a];
                hi_w[a] = hi_c[a];
            end
        end
        o_box.valid = &ok;
        for (int a = 0; a < NumAxes; a++) begin
            o_box.lo[a] = o_box.valid ? lo_w[a][CoordW-1:0] : '0;
            o_box.hi[a] = o_box.valid ? hi_w[a][CoordW-1:0] : '0;
        end
    end

endmodule

[src/voxel_line_traversal_3d_top.sv]
// ----------------------------------------------------------------------------
// voxel_line_traversal_3d_top
// Walks the grid cells crossed by a 3D segment and reports a protection box
// for every cell reached.
// ----------------------------------------------------------------------------
// an accepted word gives its result word on the output in the cycle after it is accepted
// throughput: one word per cycle while the output is not stalled; the step and box
//   logic sit in a single stage between the segment state and the output register
// reset (synchronous, active low): segment state cleared, walk idle, grid
//   sizes 1024 per axis, reach 5, output empty
module voxel_line_traversal_3d_top #(
    parameter int GRID_SIZE = vlt3_pkg::GridSizeDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [9:0]  i_start_x,
    input  logic [9:0]  i_start_y,
    input  logic [9:0]  i_start_z,
    input  logic [9:0]  i_end_x,
    input  logic [9:0]  i_end_y,
    input  logic [9:0]  i_end_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_cell_x,
    output logic [9:0]  o_cell_y,
    output logic [9:0]  o_cell_z,
    output logic [9:0]  o_box_x_low,
    output logic [9:0]  o_box_x_high,
    output logic [9:0]  o_box_y_low,
    output logic [9:0]  o_box_y_high,
    output logic [9:0]  o_box_z_low,
    output logic [9:0]  o_box_z_high,
    output logic        o_box_valid,
    output logic        o_last
);
    import vlt3_pkg::*;

    t_size [NumAxes-1:0]  r_size;
    t_reach               r_reach;
    logic                 r_out_valid;
    t_coord [NumAxes-1:0] r_cell;
    t_box                 r_box;
    logic                 r_last;

    logic                 in_fire;
    t_coord [NumAxes-1:0] start_pt, end_pt;
    t_box_req             req;
    t_box                 box;

    // output register frees up as soon as its word is taken
    assign o_stall = r_out_valid & i_stall;
    assign in_fire = i_valid & ~o_stall;

    assign start_pt = {i_start_z, i_start_y, i_start_x};
    assign end_pt   = {i_end_z, i_end_y, i_end_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= {SizeReset, SizeReset, SizeReset};
            r_reach <= ReachReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_X: r_size[0] <= i_cfg_data;
                CFG_GRID_Y: r_size[1] <= i_cfg_data;
                CFG_GRID_Z: r_size[2] <= i_cfg_data;
                CFG_REACH:  r_reach   <= i_cfg_data[ReachW-1:0];
                default:    r_reach   <= r_reach;
            endcase
        end
    end

    vlt3_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_kind  (i_kind),
        .i_start (start_pt),
        .i_end   (end_pt),
        .o_req   (req)
    );

    vlt3_box #(
        .GRID_SIZE (GRID_SIZE)
    ) u_box (
        .i_req   (req),
        .i_size  (r_size),
        .i_reach (r_reach),
        .o_box   (box)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cell <= req.pos;
            r_box  <= box;
            r_last <= req.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_x     = r_cell[0];
    assign o_cell_y     = r_cell[1];
    assign o_cell_z     = r_cell[2];
    assign o_box_x_low  = r_box.lo[0];
    assign o_box_x_high = r_box.hi[0];
    assign o_box_y_low  = r_box.lo[1];
    assign o_box_y_high = r_box.hi[1];
    assign o_box_z_low  = r_box.lo[2];
    assign o_box_z_high = r_box.hi[2];
    assign o_box_valid  = r_box.valid;
    assign o_last       = r_last;

    a_fire_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_valid)
        else $error("accepted word did not produce a result word");

    a_empty_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_box_valid) |->
            (o_box_x_low == '0 && o_box_x_high == '0 && o_box_y_low == '0 &&
             o_box_y_high == '0 && o_box_z_low == '0 && o_box_z_high == '0))
        else $error("empty box carries nonzero bounds");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_box_valid) |->
            (o_box_x_low <= o_box_x_high && o_box_y_low <= o_box_y_high &&
             o_box_z_low <= o_box_z_high))
        else $error("box bounds out of order");

    a_point_segment_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_kind == KIND_LOAD && start_pt == end_pt) |=> (o_valid && o_last))
        else $error("degenerate segment not flagged last");

endmodule
